// ----- rtl/core/mer_pkg.sv -----
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and fixed widths of the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
package mer_pkg;

  localparam int CFG_W       = 10;  // configuration register width
  localparam int RSQ_W       = 20;  // squared radius width
  localparam int DEC_W       = 48;  // decision variable width
  localparam int PIX_W       = 12;  // pixel coordinate width
  localparam int QUEUE_DEPTH = 2;   // items held between front and back

  typedef logic [DEC_W-1:0] dec_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [CFG_W-1:0] center_x;
    logic [CFG_W-1:0] center_y;
    logic [CFG_W-1:0] radius_x;
    logic [CFG_W-1:0] radius_y;
  } cfg_t;

  // head of the item queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic restart;
  } qhead_t;

endpackage

// ----- rtl/core/mer_front.sv -----
// ----------------------------------------------------------------------------
// mer_front
// Accepts input beats and holds them in a short queue for the walker.
// ----------------------------------------------------------------------------
module mer_front import mer_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   restart,
  input  logic   pop,
  output qhead_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             entry [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pull;

  assign in_stall     = (count == CNT_W'(QUEUE_DEPTH));
  assign push         = in_valid && !in_stall;
  assign head.valid   = (count != '0);
  assign head.restart = entry[rd_ptr];
  assign pull         = pop && head.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= restart;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pull) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pull) begin
        count <= count + 1'b1;
      end else if (pull && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/mer_back.sv -----
// ----------------------------------------------------------------------------
// mer_back
// Walker: emits the four symmetric pixels of a point, then advances the
// midpoint decision variable through a shared multiplier sequence.
// ----------------------------------------------------------------------------
module mer_back import mer_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  qhead_t                  head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    final_point,
  output logic                    last_of_run
);

  localparam int CW   = COORD_BITS;
  localparam int MB_W = (2 * CW > RSQ_W) ? 2 * CW : RSQ_W;
  localparam int PR_W = RSQ_W + MB_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_INIT  = 4'd2;
  localparam logic [3:0] ST_EMIT  = 4'd3;
  localparam logic [3:0] ST_MX    = 4'd4;
  localparam logic [3:0] ST_MY    = 4'd5;
  localparam logic [3:0] ST_CMP   = 4'd6;
  localparam logic [3:0] ST_UPD1  = 4'd7;
  localparam logic [3:0] ST_SQX   = 4'd8;
  localparam logic [3:0] ST_MSX   = 4'd9;
  localparam logic [3:0] ST_ACC1  = 4'd10;
  localparam logic [3:0] ST_MSY   = 4'd11;
  localparam logic [3:0] ST_ACC2  = 4'd12;
  localparam logic [3:0] ST_ACC3  = 4'd13;
  localparam logic [3:0] ST_R2    = 4'd14;
  localparam logic [3:0] ST_UPD2  = 4'd15;

  localparam logic [1:0] BEAT_LAST = 2'd3;

  logic [3:0]       state;
  logic [CW-1:0]    x_pos;
  logic [CW-1:0]    y_pos;
  dec_t             decision;
  logic             region_two;
  logic             finished;
  logic [1:0]       beat;
  logic             step_flag;
  dec_t             ta;
  dec_t             tb;
  dec_t             prod;
  logic [RSQ_W-1:0] rx2;
  logic [RSQ_W-1:0] ry2;

  logic [RSQ_W-1:0] mul_a;
  logic [MB_W-1:0]  mul_b;
  logic [PR_W-1:0]  mul_full;
  logic [CW-1:0]    y_less;
  logic             x_max;
  dec_t             rx2_d;
  dec_t             ry2_d;
  logic             dec_pos;
  logic             emit_load;
  pix_t             cx_pix;
  pix_t             cy_pix;
  pix_t             x_pix;
  pix_t             y_pix;

  assign y_less    = y_pos - 1'b1;
  assign x_max     = &x_pos;
  assign rx2_d     = DEC_W'(rx2);
  assign ry2_d     = DEC_W'(ry2);
  assign dec_pos   = !decision[DEC_W-1] && (decision != '0);
  assign pop       = (state == ST_IDLE);
  assign emit_load = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign cx_pix    = PIX_W'(cfg.center_x);
  assign cy_pix    = PIX_W'(cfg.center_y);
  assign x_pix     = PIX_W'(x_pos);
  assign y_pix     = PIX_W'(y_pos);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_START: begin
        mul_a = rx2;
        mul_b = MB_W'(cfg.radius_y);
      end
      ST_MX: begin
        mul_a = ry2;
        mul_b = MB_W'(x_pos);
      end
      ST_MY: begin
        mul_a = rx2;
        mul_b = MB_W'(y_pos);
      end
      ST_SQX: begin
        mul_a = RSQ_W'(x_pos);
        mul_b = MB_W'(x_pos);
      end
      ST_MSX: begin
        mul_a = ry2;
        mul_b = MB_W'(prod[2*CW-1:0]);
      end
      ST_ACC1: begin
        mul_a = RSQ_W'(y_less);
        mul_b = MB_W'(y_less);
      end
      ST_MSY: begin
        mul_a = rx2;
        mul_b = MB_W'(prod[2*CW-1:0]);
      end
      ST_ACC2: begin
        mul_a = rx2;
        mul_b = MB_W'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = PR_W'(mul_a) * PR_W'(mul_b);

  always_ff @(posedge clk) begin
    rx2  <= RSQ_W'(cfg.radius_x) * RSQ_W'(cfg.radius_x);
    ry2  <= RSQ_W'(cfg.radius_y) * RSQ_W'(cfg.radius_y);
    prod <= DEC_W'(mul_full);
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      pixel_x     <= beat[1] ? cx_pix - x_pix : cx_pix + x_pix;
      pixel_y     <= beat[0] ? cy_pix - y_pix : cy_pix + y_pix;
      final_point <= (y_pos == '0);
      last_of_run <= (beat == BEAT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      x_pos      <= '0;
      y_pos      <= '0;
      decision   <= '0;
      region_two <= 1'b0;
      finished   <= 1'b1;
      beat       <= '0;
      step_flag  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            if (head.restart) begin
              state <= ST_START;
            end else if (!finished) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_START: begin
          state <= ST_INIT;
        end
        ST_INIT: begin
          decision   <= (ry2_d << 2) - (prod << 2) + rx2_d;
          x_pos      <= '0;
          y_pos      <= CW'(cfg.radius_y);
          region_two <= 1'b0;
          finished   <= 1'b0;
          state      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_load) begin
            beat <= beat + 1'b1;
            if (beat == BEAT_LAST) begin
              if (y_pos == '0) begin
                finished <= 1'b1;
                state    <= ST_IDLE;
              end else begin
                state <= ST_MX;
              end
            end
          end
        end
        ST_MX: begin
          state <= ST_MY;
        end
        ST_MY: begin
          ta    <= prod;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (region_two) begin
            tb    <= prod;
            state <= ST_R2;
          end else if (ta < prod) begin
            if (!x_max) begin
              x_pos <= x_pos + 1'b1;
              ta    <= ta + ry2_d;
            end
            if (!decision[DEC_W-1]) begin
              y_pos <= y_less;
              tb    <= prod - rx2_d;
            end else begin
              tb <= prod;
            end
            step_flag <= !decision[DEC_W-1];
            state     <= ST_UPD1;
          end else begin
            region_two <= 1'b1;
            tb         <= prod;
            state      <= ST_SQX;
          end
        end
        ST_UPD1: begin
          decision <= decision + (ta << 3) + (ry2_d << 2) - (step_flag ? (tb << 3) : '0);
          state    <= ST_IDLE;
        end
        ST_SQX: begin
          state <= ST_MSX;
        end
        ST_MSX: begin
          state <= ST_ACC1;
        end
        ST_ACC1: begin
          decision <= (prod << 2) + (ta << 2) + ry2_d;
          state    <= ST_MSY;
        end
        ST_MSY: begin
          state <= ST_ACC2;
        end
        ST_ACC2: begin
          decision <= decision + (prod << 2);
          state    <= ST_ACC3;
        end
        ST_ACC3: begin
          decision <= decision - (prod << 2);
          state    <= ST_R2;
        end
        ST_R2: begin
          y_pos <= y_less;
          tb    <= tb - rx2_d;
          if (!dec_pos && !x_max) begin
            x_pos <= x_pos + 1'b1;
            ta    <= ta + ry2_d;
          end
          step_flag <= dec_pos;
          state     <= ST_UPD2;
        end
        ST_UPD2: begin
          if (step_flag) begin
            decision <= decision + (rx2_d << 2) - (tb << 3);
          end else begin
            decision <= decision + (ta << 3) - (tb << 3) + (rx2_d << 2);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse walker with a queued input side and a sequenced back end.
//
// Set center_x, center_y, radius_x and radius_y through the write port
// (indexes 0 to 3) while the block is idle. Each input beat carries restart:
// 1 starts a new ellipse at (0, radius_y), 0 advances one point. While a walk
// is active, every item yields four output beats, the symmetric pixels of
// the current point, the fourth with last_of_run set; final_point marks the
// point with y equal to zero. After that point, advance items yield nothing.
// Input beats enter a two-entry queue, so in_stall rises only when it is full.
// After an advance item is accepted the first pixel is loaded in the EMIT
// state; a restart passes START and INIT first. Each point gives 4 output
// beats, then the decision update through one shared multiplier, one
// product per cycle.
// A stalled output holds its beat and the walker waits for it.
// Reset clears the configuration to zero, empties the queue and leaves the
// walk finished, so nothing is drawn until a restart.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    restart,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] pixel_x,
  output logic signed [PIX_W-1:0] pixel_y,
  output logic                    final_point,
  output logic                    last_of_run
);

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS_X = 2'd2;
  localparam logic [1:0] REG_RADIUS_Y = 2'd3;

  cfg_t       cfg;
  qhead_t     head;
  logic       pop;
  logic [1:0] beat_cnt;
  pix_t       cy_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X: cfg.center_x <= cfg_data;
        REG_CENTER_Y: cfg.center_y <= cfg_data;
        REG_RADIUS_X: cfg.radius_x <= cfg_data;
        REG_RADIUS_Y: cfg.radius_y <= cfg_data;
        default:      cfg          <= cfg;
      endcase
    end
  end

  mer_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .restart  (restart),
    .pop      (pop),
    .head     (head)
  );

  mer_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .final_point (final_point),
    .last_of_run (last_of_run)
  );

  // count delivered beats within a point
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_cnt <= '0;
    end else if (out_valid && !out_stall) begin
      beat_cnt <= beat_cnt + 1'b1;
    end
  end

  assign cy_pix = PIX_W'(cfg.center_y);

  a_run_marks_fourth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |-> (last_of_run == (beat_cnt == 2'd3)))
    else $error("last_of_run out of step with beat count");

  a_final_on_axis: assert property (@(posedge clk) disable iff (rst)
    (out_valid && final_point) |-> (pixel_y == cy_pix))
    else $error("final point off the horizontal axis");

  a_reset_quiet: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

// ----- tb/tb_midpoint_ellipse_rasterizer.sv -----
// ----------------------------------------------------------------------------
// tb_midpoint_ellipse_rasterizer
// Self-checking bench for the midpoint ellipse rasterizer. A local walker
// tracks center, radii, the current point and the decision term. It queues
// the four symmetric pixels for every accepted item of an active walk. Each output beat is
// compared against that queue. Directed cases cover the idle walk, zero
// radii, restarts mid-walk and a full-size ellipse. Random ellipses follow
// under four idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_midpoint_ellipse_rasterizer;
  import mer_pkg::*;

  localparam int COORD_BITS    = 10;
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_QUOTA  = 12;

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_RADIUS_X = 2'd2,
    REG_RADIUS_Y = 2'd3
  } reg_index_e;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct {
    pix_t x;
    pix_t y;
    bit   fin;
    bit   is_last;
  } plotted_pixel_t;

  logic                    clk;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  reg_index_e              cfg_index = REG_CENTER_X;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic                    restart   = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic                    final_point;
  logic                    last_of_run;

  // walker state, mirrors the block after reset
  bit [CFG_W-1:0]      ctr_x, ctr_y, rad_x, rad_y;
  bit [COORD_BITS-1:0] walk_x, walk_y;
  dec_t                walk_dec     = '0;
  bit                  walk_region2 = 1'b0;
  bit                  walk_done    = 1'b1;

  plotted_pixel_t pixel_q[$];
  int             mismatches  = 0;
  int             walk_items  = 0;
  int             send_idle_pct = 0;
  int             stall_pct     = 0;

  midpoint_ellipse_rasterizer #(.COORD_BITS(COORD_BITS)) u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .final_point (final_point),
    .last_of_run (last_of_run)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // advance the point by one midpoint step
  function automatic void step_walk();
    longint unsigned rx2, ry2, d, xv, yv, tx, ty;
    rx2 = longint'(rad_x) * rad_x;
    ry2 = longint'(rad_y) * rad_y;
    d   = 64'(walk_dec);
    xv  = 64'(walk_x);
    yv  = 64'(walk_y);
    if (!walk_region2) begin
      if (ry2 * xv < rx2 * yv) begin
        if (walk_x != '1) walk_x++;
        xv = 64'(walk_x);
        if (d[DEC_W-1]) begin
          d += 8 * ry2 * xv + 4 * ry2;
        end else begin
          walk_y--;
          yv = 64'(walk_y);
          d += 8 * ry2 * xv + 4 * ry2 - 8 * rx2 * yv;
        end
        walk_dec = dec_t'(d);
        return;
      end
      walk_region2 = 1'b1;
      tx = 2 * xv + 1;
      ty = yv - 1;
      d  = ry2 * tx * tx + 4 * rx2 * ty * ty - 4 * rx2 * ry2;
    end
    d = 64'(dec_t'(d));
    if (!d[DEC_W-1] && d != 0) begin
      walk_y--;
      yv = 64'(walk_y);
      d += 4 * rx2 - 8 * rx2 * yv;
    end else begin
      if (walk_x != '1) walk_x++;
      walk_y--;
      xv = 64'(walk_x);
      yv = 64'(walk_y);
      d += 8 * ry2 * xv - 8 * rx2 * yv + 4 * rx2;
    end
    walk_dec = dec_t'(d);
  endfunction

  // queue the pixels of one accepted item, return how many
  function automatic int plot_item(input bit rs);
    longint unsigned rx2, ry2, cx, cy, xv, yv;
    pix_t            px[2], py[2];
    bit              fin;
    if (rs) begin
      rx2          = longint'(rad_x) * rad_x;
      ry2          = longint'(rad_y) * rad_y;
      walk_x       = '0;
      walk_y       = COORD_BITS'(rad_y);
      walk_region2 = 1'b0;
      walk_done    = 1'b0;
      walk_dec     = dec_t'(4 * ry2 - 4 * rx2 * rad_y + rx2);
    end
    if (walk_done) return 0;
    cx    = 64'(ctr_x);
    cy    = 64'(ctr_y);
    xv    = 64'(walk_x);
    yv    = 64'(walk_y);
    px[0] = pix_t'(cx + xv);
    px[1] = pix_t'(cx - xv);
    py[0] = pix_t'(cy + yv);
    py[1] = pix_t'(cy - yv);
    fin   = (walk_y == 0);
    for (int k = 0; k < 4; k++) begin
      pixel_q.push_back('{px[k >> 1], py[k & 1], fin, k == 3});
    end
    if (fin) walk_done = 1'b1;
    else step_walk();
    return 4;
  endfunction

  always @(posedge clk) begin : check_pixels
    plotted_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected pixel beat: x=%0d y=%0d final=%0b last=%0b",
                   pixel_x, pixel_y, final_point, last_of_run);
        end
        mismatches++;
      end else begin
        want = pixel_q.pop_front();
        if (pixel_x !== want.x || pixel_y !== want.y ||
            final_point !== want.fin || last_of_run !== want.is_last) begin
          if (mismatches < 10) begin
            $write("pixel mismatch: expected x=%0d y=%0d final=%0b last=%0b, ",
                   $signed(want.x), $signed(want.y), want.fin, want.is_last);
            $display("got x=%0d y=%0d final=%0b last=%0b",
                     pixel_x, pixel_y, final_point, last_of_run);
          end
          mismatches++;
        end
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 67;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 67;
      end
      default: begin
        send_idle_pct = 30;
        stall_pct     = 30;
      end
    endcase
  endtask

  task automatic send_item(input bit rs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      restart  <= 1'($urandom_range(1));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    if (plot_item(rs) != 0) walk_items++;
  endtask

  // drop valid and wait for every queued pixel, then extra cycles
  task automatic hold_until_drained(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] cx, cy, rx, ry);
    hold_until_drained(SETTLE_CYCLES);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_RADIUS_X, rx);
    write_reg(REG_RADIUS_Y, ry);
    cfg_we <= 1'b0;
    ctr_x  = cx;
    ctr_y  = cy;
    rad_x  = rx;
    rad_y  = ry;
  endtask

  task automatic walk_to_end();
    while (!walk_done) send_item(1'b0);
  endtask

  task automatic test_idle_after_reset();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_zero_radius_y();
    configure(10'd1023, 10'd1023, 10'd1023, 10'd0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_zero_radius_x();
    configure(10'd0, 10'd0, 10'd0, 10'd5);
    send_item(1'b1);
    walk_to_end();
    send_item(1'b0);
  endtask

  task automatic test_restart_mid_walk();
    configure(10'd512, 10'd300, 10'd6, 10'd4);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    hold_until_drained(0);
    send_item(1'b1);
    walk_to_end();
    send_item(1'b0);
  endtask

  task automatic test_full_size_walk();
    set_idling(IDLE_NONE);
    configure(10'd1023, 10'd0, 10'd1023, 10'd1023);
    send_item(1'b1);
    repeat (8) send_item(1'b0);
  endtask

  task automatic test_random_walks(input idle_mode_e mode);
    int               first, span;
    bit               wide;
    logic [CFG_W-1:0] rx, ry;
    set_idling(mode);
    first = walk_items;
    while (walk_items - first < RANDOM_QUOTA) begin
      wide = ($urandom_range(7) == 0);
      rx   = CFG_W'($urandom_range(12));
      ry   = CFG_W'($urandom_range(12));
      if (wide) begin
        if ($urandom_range(1)) rx = CFG_W'($urandom_range(13, 1023));
        else ry = CFG_W'($urandom_range(13, 1023));
      end
      configure(CFG_W'($urandom_range(1023)), CFG_W'($urandom_range(1023)), rx, ry);
      if ($urandom_range(5) == 0) send_item(1'b0);
      send_item(1'b1);
      if (!wide && $urandom_range(9) < 7) begin
        walk_to_end();
        repeat ($urandom_range(2)) send_item(1'b0);
      end else begin
        span = $urandom_range(1, 8);
        repeat (span) send_item($urandom_range(15) == 0);
        if ($urandom_range(3) == 0) hold_until_drained(0);
        repeat ($urandom_range(4)) send_item(1'b0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_idling(IDLE_BOTH);
    test_idle_after_reset();
    test_zero_radius_y();
    test_zero_radius_x();
    test_restart_mid_walk();
    test_full_size_walk();
    test_random_walks(IDLE_NONE);
    test_random_walks(IDLE_SENDER);
    test_random_walks(IDLE_RECEIVER);
    test_random_walks(IDLE_BOTH);
    hold_until_drained(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
